// File: rtl/wmps_pkg.sv
// Shared constants, codes and types of the waveform min/max peak store.
package wmps_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int DISP_W  = 12;
  localparam int SPB_W   = 13;
  localparam int RANGE_W = 28;
  localparam int BUCKET_MAX = 4096;
  localparam int FILL_W  = $clog2(BUCKET_MAX);
  localparam int PROD_W  = DISP_W + RANGE_W;
  localparam int POS_W   = PROD_W + 1;
  localparam int FR_W    = POS_W - FRAC_BITS;
  localparam int LR_W    = POS_W + 1 - FRAC_BITS;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [SPB_W-1:0]   SPB_RESET  = SPB_W'(512);
  localparam logic [RANGE_W-1:0] STEP_RESET = RANGE_W'(65536);

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_EOS   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_SPB   = 2'd0,
    REG_START = 2'd1,
    REG_STEP  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    Q_IDLE,
    Q_ADD,
    Q_FIRST,
    Q_LAST,
    Q_WALK,
    Q_DRAIN,
    Q_RESULT
  } query_state_t;

  typedef struct packed {
    logic [SPB_W-1:0]   spb;
    logic [RANGE_W-1:0] start;
    logic [RANGE_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic                          en;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] min_val;
    logic signed [SAMPLE_BITS-1:0] max_val;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic [CNT_W-1:0] stored;
    logic             overflow;
  } store_stat_t;

endpackage

// File: rtl/wmps_regs.sv
// Configuration register file behind the APB-style port.
module wmps_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wmps_pkg::PADDR_W-1:0] paddr,
  input  logic [wmps_pkg::PDATA_W-1:0] pwdata,
  output logic [wmps_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output wmps_pkg::cfg_t               cfg
);
  import wmps_pkg::*;

  reg_idx_t idx;
  logic     wr_fire;

  assign idx     = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spb   <= SPB_RESET;
      cfg.start <= '0;
      cfg.step  <= STEP_RESET;
    end else if (wr_fire) begin
      unique case (idx)
        REG_SPB:   cfg.spb   <= pwdata[SPB_W-1:0];
        REG_START: cfg.start <= pwdata[RANGE_W-1:0];
        REG_STEP:  cfg.step  <= pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPB:   prdata = PDATA_W'(cfg.spb);
      REG_START: prdata = PDATA_W'(cfg.start);
      REG_STEP:  prdata = PDATA_W'(cfg.step);
      default:   prdata = '0;
    endcase
  end

endmodule

// File: rtl/wmps_peak_mem.sv
// Peak memories: one for bucket minima, one for bucket maxima, registered read.
module wmps_peak_mem (
  input  logic                                  clk,
  input  wmps_pkg::mem_wr_t                     wr,
  input  wmps_pkg::mem_rd_t                     rd,
  output logic signed [wmps_pkg::SAMPLE_BITS-1:0] rd_min,
  output logic signed [wmps_pkg::SAMPLE_BITS-1:0] rd_max
);
  import wmps_pkg::*;

  logic signed [SAMPLE_BITS-1:0] min_mem [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] max_mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      min_mem[wr.addr] <= wr.min_val;
      max_mem[wr.addr] <= wr.max_val;
    end
    if (rd.en) begin
      rd_min <= min_mem[rd.addr];
      rd_max <= max_mem[rd.addr];
    end
  end

endmodule

// File: rtl/wmps_accum.sv
// Bucket accumulator: running min/max, fill count and store bookkeeping.
module wmps_accum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_fire,
  input  wmps_pkg::func_t                       func,
  input  logic signed [wmps_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [wmps_pkg::SPB_W-1:0]            spb,
  output wmps_pkg::mem_wr_t                     wr,
  output wmps_pkg::store_stat_t                 stat
);
  import wmps_pkg::*;

  logic signed [SAMPLE_BITS-1:0] run_min;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic signed [SAMPLE_BITS-1:0] new_min;
  logic signed [SAMPLE_BITS-1:0] new_max;
  logic [FILL_W-1:0] fill;
  logic [SPB_W-1:0]  fill_inc;
  logic [SPB_W-1:0]  len;
  logic [CNT_W-1:0]  stored;
  logic              overflow;
  logic push, closing, clearing, full;

  // A zero length acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (spb == '0) len = SPB_W'(1);
    else if (spb > SPB_W'(BUCKET_MAX)) len = SPB_W'(BUCKET_MAX);
    else len = spb;
  end

  assign new_min  = (sample < run_min) ? sample : run_min;
  assign new_max  = (sample > run_max) ? sample : run_max;
  assign fill_inc = {1'b0, fill} + SPB_W'(1);
  assign push     = in_fire && (func == FUNC_PUSH);
  assign clearing = in_fire && (func == FUNC_CLEAR);
  assign closing  = (push && (fill_inc >= len)) ||
                    (in_fire && (func == FUNC_EOS) && (fill != '0));
  assign full     = (stored == CNT_W'(STORE_DEPTH));

  assign wr.en      = closing && !full;
  assign wr.addr    = stored[ADDR_W-1:0];
  assign wr.min_val = push ? new_min : run_min;
  assign wr.max_val = push ? new_max : run_max;

  assign stat.stored   = stored;
  assign stat.overflow = overflow;

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      run_min  <= '0;
      run_max  <= '0;
      fill     <= '0;
      stored   <= '0;
      overflow <= 1'b0;
    end else if (closing) begin
      run_min <= '0;
      run_max <= '0;
      fill    <= '0;
      if (full) overflow <= 1'b1;
      else stored <= stored + CNT_W'(1);
    end else if (push) begin
      run_min <= new_min;
      run_max <= new_max;
      fill    <= fill_inc[FILL_W-1:0];
    end
  end

endmodule

// File: rtl/wmps_query.sv
// Query sequencer: maps a display bucket to a source range and walks the peak memories.
module wmps_query (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [wmps_pkg::DISP_W-1:0]           display_index,
  input  wmps_pkg::cfg_t                        cfg,
  input  wmps_pkg::store_stat_t                 stat,
  input  logic signed [wmps_pkg::SAMPLE_BITS-1:0] rd_min,
  input  logic signed [wmps_pkg::SAMPLE_BITS-1:0] rd_max,
  input  logic                                  out_stall,
  output logic                                  busy,
  output wmps_pkg::mem_rd_t                     rd,
  output logic                                  out_valid,
  output logic signed [wmps_pkg::SAMPLE_BITS-1:0] min_peak,
  output logic signed [wmps_pkg::SAMPLE_BITS-1:0] max_peak,
  output logic [wmps_pkg::DISP_W-1:0]           answered_index,
  output logic                                  store_empty,
  output logic                                  store_full
);
  import wmps_pkg::*;

  query_state_t state, state_next;

  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  pos;
  logic [POS_W:0]    pos_end;
  logic [FR_W-1:0]   first_raw;
  logic [LR_W-1:0]   last_raw;
  logic [CNT_W-1:0]  first;
  logic [CNT_W-1:0]  first_inc;
  logic [CNT_W-1:0]  end_cnt;
  logic [CNT_W-1:0]  end_clamp;
  logic [CNT_W-1:0]  addr;
  logic [CNT_W-1:0]  n;
  logic [DISP_W-1:0] disp;
  logic              full_q;
  logic              empty_q;
  logic              rd_pend;
  logic              load;
  logic signed [SAMPLE_BITS-1:0] lo;
  logic signed [SAMPLE_BITS-1:0] hi;

  assign busy      = (state != Q_IDLE);
  assign first_raw = pos[POS_W-1:FRAC_BITS];
  assign pos_end   = {1'b0, pos} + (POS_W+1)'(cfg.step);
  assign first_inc = first + CNT_W'(1);

  // The first bucket never exceeds n - 1, so first + 1 never exceeds n.
  always_comb begin
    if (last_raw < LR_W'(first_inc)) end_clamp = first_inc;
    else if (last_raw > LR_W'(n)) end_clamp = n;
    else end_clamp = last_raw[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= Q_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    rd.en      = 1'b0;
    rd.addr    = addr[ADDR_W-1:0];
    load       = 1'b0;
    unique case (state)
      Q_IDLE: begin
        if (start) state_next = (stat.stored == '0) ? Q_RESULT : Q_ADD;
      end
      Q_ADD:   state_next = Q_FIRST;
      Q_FIRST: state_next = Q_LAST;
      Q_LAST:  state_next = Q_WALK;
      Q_WALK: begin
        rd.en = 1'b1;
        if (addr + CNT_W'(1) == end_cnt) state_next = Q_DRAIN;
      end
      Q_DRAIN: state_next = Q_RESULT;
      Q_RESULT: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = Q_IDLE;
        end
      end
      default: state_next = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= rd.en;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == Q_IDLE && start) begin
      prod    <= PROD_W'(display_index) * PROD_W'(cfg.step);
      disp    <= display_index;
      n       <= stat.stored;
      full_q  <= stat.overflow;
      empty_q <= (stat.stored == '0);
      lo      <= '0;
      hi      <= '0;
    end
    if (state == Q_ADD) pos <= POS_W'(cfg.start) + POS_W'(prod);
    if (state == Q_FIRST) begin
      if (first_raw > FR_W'(n - CNT_W'(1))) first <= n - CNT_W'(1);
      else first <= first_raw[CNT_W-1:0];
      last_raw <= pos_end[POS_W:FRAC_BITS] + LR_W'(1);
    end
    if (state == Q_LAST) begin
      end_cnt <= end_clamp;
      addr    <= first;
    end
    if (state == Q_WALK) addr <= addr + CNT_W'(1);
    if (rd_pend) begin
      if (rd_min < lo) lo <= rd_min;
      if (rd_max > hi) hi <= rd_max;
    end
    if (load) begin
      min_peak       <= lo;
      max_peak       <= hi;
      answered_index <= disp;
      store_empty    <= empty_q;
      store_full     <= full_q;
    end
  end

endmodule

// File: rtl/waveform_minmax_peak_store_unit.sv
// Top level of the waveform min/max peak store: sample bucketing and ranged peak queries.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------
//   in      | input     | in_valid / in_stall      | func, sample, display_index
//   out     | output    | out_valid / out_stall    | min_peak, max_peak, answered_index,
//           |           |                          | store_empty, store_full
//   cfg     | input     | psel / penable / pready  | paddr, pwdata, prdata
//
// A push, end-of-stream or clear beat never holds the input; the next beat can follow at once.
// A query holds the input from its accept through the add, first, last, walk, drain and
// result states; the memory walk reads one bucket per cycle through the single read port.
// A query on an empty store goes straight to the result state and skips the walk.
// Reset is synchronous; it clears the bucket bookkeeping but not the peak memories, so no
// clearing pass runs. The result sits in an output register, so a stalled output only
// blocks a later query when that query is ready to deliver.
module waveform_minmax_peak_store_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            func,
  input  logic signed [wmps_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [wmps_pkg::DISP_W-1:0]           display_index,
  // Output channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wmps_pkg::SAMPLE_BITS-1:0] min_peak,
  output logic signed [wmps_pkg::SAMPLE_BITS-1:0] max_peak,
  output logic [wmps_pkg::DISP_W-1:0]           answered_index,
  output logic                                  store_empty,
  output logic                                  store_full,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wmps_pkg::PADDR_W-1:0]          paddr,
  input  logic [wmps_pkg::PDATA_W-1:0]          pwdata,
  output logic [wmps_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);
  import wmps_pkg::*;

  cfg_t        cfg;
  mem_wr_t     wr;
  mem_rd_t     rd;
  store_stat_t stat;
  func_t       func_code;
  logic        in_fire;
  logic        busy;
  logic signed [SAMPLE_BITS-1:0] rd_min;
  logic signed [SAMPLE_BITS-1:0] rd_max;

  // The input is held off only while a query is being worked on. Pushes never touch
  // the memory entries a query reads, because a query finishes before the next beat.
  assign in_stall  = busy;
  assign in_fire   = in_valid && !in_stall;
  assign func_code = func_t'(func);

  wmps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Folds samples into the running bucket and writes closed buckets to memory.
  wmps_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .func    (func_code),
    .sample  (sample),
    .spb     (cfg.spb),
    .wr      (wr),
    .stat    (stat)
  );

  wmps_peak_mem u_mem (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .rd_min (rd_min),
    .rd_max (rd_max)
  );

  // Maps the display bucket, walks the range and holds the result beat.
  wmps_query u_query (
    .clk            (clk),
    .rst            (rst),
    .start          (in_fire && (func_code == FUNC_QUERY)),
    .display_index  (display_index),
    .cfg            (cfg),
    .stat           (stat),
    .rd_min         (rd_min),
    .rd_max         (rd_max),
    .out_stall      (out_stall),
    .busy           (busy),
    .rd             (rd),
    .out_valid      (out_valid),
    .min_peak       (min_peak),
    .max_peak       (max_peak),
    .answered_index (answered_index),
    .store_empty    (store_empty),
    .store_full     (store_full)
  );

endmodule

// File: tb/tb_waveform_minmax_peak_store_unit.sv
// Self-checking testbench for the waveform min/max peak store: bucketing, overflow, queries.
`timescale 1ns / 1ps

module tb_waveform_minmax_peak_store_unit;
  import wmps_pkg::*;

  // Give up after this many cycles.
  localparam int LIMIT_CYCLES = 3_000_000;
  // Cycles allowed after the last answer for a trailing push to settle.
  localparam int SETTLE_CYCLES = 16;
  // Length of the one long hold-off on the output side.
  localparam int HOLD_CYCLES = 400;
  // Cap on printed mismatch lines.
  localparam int MAX_REPORTS = 40;

  // One query answer, as predicted or as seen on the output ports.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] min_pk;
    logic signed [SAMPLE_BITS-1:0] max_pk;
    logic [DISP_W-1:0]             idx;
    logic                          empty;
    logic                          full;
  } peak_result_t;

  // The scoreboard mirrors the bucket store. Every accepted input beat is
  // applied in accept order; a query pushes the answer the block must give.
  class peak_scoreboard;
    logic [SPB_W-1:0]              spb;
    logic [RANGE_W-1:0]            win_start;
    logic [RANGE_W-1:0]            win_step;
    logic signed [SAMPLE_BITS-1:0] min_mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] max_mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] run_min;
    logic signed [SAMPLE_BITS-1:0] run_max;
    int unsigned                   fill;
    int unsigned                   stored;
    bit                            dropped;
    peak_result_t                  pending_answers[$];
    int errors, reported, beats, closed, lost, answered;

    function new();
      spb       = SPB_RESET;
      win_start = '0;
      win_step  = STEP_RESET;
      errors    = 0;
      reported  = 0;
      beats     = 0;
      closed    = 0;
      lost      = 0;
      answered  = 0;
      empty_store();
    endfunction

    function void empty_store();
      run_min = '0;
      run_max = '0;
      fill    = 0;
      stored  = 0;
      dropped = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_SPB:   spb       = value[SPB_W-1:0];
        REG_START: win_start = value[RANGE_W-1:0];
        REG_STEP:  win_step  = value[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    // A length of zero behaves as one; anything past the maximum is clipped.
    function int unsigned bucket_len();
      if (spb == '0) return 1;
      if (spb > BUCKET_MAX) return BUCKET_MAX;
      return 32'(spb);
    endfunction

    // A bucket closed on a full store is lost, but its running values still clear.
    function void close_bucket();
      if (stored < STORE_DEPTH) begin
        min_mem[stored] = run_min;
        max_mem[stored] = run_max;
        stored++;
        closed++;
      end else begin
        dropped = 1'b1;
        lost++;
      end
      run_min = '0;
      run_max = '0;
      fill    = 0;
    endfunction

    function void apply_beat(func_t f, logic signed [SAMPLE_BITS-1:0] s,
                             logic [DISP_W-1:0] d);
      peak_result_t                  r;
      longint unsigned               pos, first, last, j;
      logic signed [SAMPLE_BITS-1:0] lo, hi;
      beats++;
      case (f)
        FUNC_PUSH: begin
          if (s < run_min) run_min = s;
          if (s > run_max) run_max = s;
          fill++;
          if (fill >= bucket_len()) close_bucket();
        end
        FUNC_EOS: begin
          if (fill > 0) close_bucket();
        end
        FUNC_CLEAR: begin
          empty_store();
        end
        default: begin
          // The peaks are taken against zero, so an empty store reads as zeros.
          lo = '0;
          hi = '0;
          if (stored != 0) begin
            pos   = 64'(win_start) + 64'(d) * 64'(win_step);
            first = pos >> FRAC_BITS;
            last  = ((pos + 64'(win_step)) >> FRAC_BITS) + 1;
            if (first > stored - 1) first = stored - 1;
            if (last < first + 1) last = first + 1;
            if (last > stored) last = stored;
            for (j = first; j < last; j++) begin
              if (min_mem[j] < lo) lo = min_mem[j];
              if (max_mem[j] > hi) hi = max_mem[j];
            end
          end
          r.min_pk = lo;
          r.max_pk = hi;
          r.idx    = d;
          r.empty  = (stored == 0);
          r.full   = dropped;
          pending_answers.push_back(r);
        end
      endcase
    endfunction

    function void compare(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        errors++;
        if (reported < MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        reported++;
      end
    endfunction

    function void check_answer(peak_result_t got);
      peak_result_t want;
      answered++;
      if (pending_answers.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS)
          $display("%0t: answer for index %0d with no query waiting", $time, got.idx);
        reported++;
        return;
      end
      want = pending_answers.pop_front();
      compare("min_peak", 32'(want.min_pk), 32'(got.min_pk));
      compare("max_peak", 32'(want.max_pk), 32'(got.max_pk));
      compare("answered_index", 32'(want.idx), 32'(got.idx));
      compare("store_empty", 32'(want.empty), 32'(got.empty));
      compare("store_full", 32'(want.full), 32'(got.full));
    endfunction
  endclass

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input channel.
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    func = FUNC_PUSH;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic [DISP_W-1:0]             display_index = '0;

  // Output channel.
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] min_peak;
  logic signed [SAMPLE_BITS-1:0] max_peak;
  logic [DISP_W-1:0]             answered_index;
  logic                          store_empty;
  logic                          store_full;

  // Configuration port.
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [PADDR_W-1:0]            paddr = '0;
  logic [PDATA_W-1:0]            pwdata = '0;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;

  peak_scoreboard sb;
  peak_result_t   seen;
  int             cycles = 0;
  int             reg_writes = 0;
  bit             quiet_in = 1'b0;   // no idle gaps on the input side
  bit             quiet_out = 1'b0;  // no stall bursts on the output side
  bit             hold_req = 1'b0;   // ask the receiver for its long hold-off

  waveform_minmax_peak_store_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .sample         (sample),
    .display_index  (display_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .min_peak       (min_peak),
    .max_peak       (max_peak),
    .answered_index (answered_index),
    .store_empty    (store_empty),
    .store_full     (store_full),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d answers outstanding", cycles,
               sb.pending_answers.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output monitor. Port values read right at the edge are the ones the edge
  // samples, since all testbench drives are nonblocking.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      seen.min_pk = min_peak;
      seen.max_pk = max_peak;
      seen.idx    = answered_index;
      seen.empty  = store_empty;
      seen.full   = store_full;
      sb.check_answer(seen);
    end
  end

  // Receiver. Short random stall bursts, one long hold-off on request, and
  // none at all once the quiet flag is up.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Samples lean on the extremes now and then so the running min and max see them.
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Most queries ask about low display buckets so that the mapped range lands
  // inside the store; the rest use the whole index range and hit the clamp.
  function automatic logic [DISP_W-1:0] rand_disp();
    if ($urandom_range(0, 9) < 7) return DISP_W'($urandom_range(0, 63));
    return DISP_W'($urandom);
  endfunction

  // Offers one input beat and returns at the edge that accepts it. Starts and
  // ends at a rising edge, with at most one update of in_valid per edge.
  task automatic send_beat(func_t f, logic signed [SAMPLE_BITS-1:0] s, logic [DISP_W-1:0] d);
    if (!quiet_in && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    sample        <= s;
    display_index <= d;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.apply_beat(f, s, d);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, value);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the block idle: every answer back, then the settle wait
  // for a push that may still be in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(logic [SPB_W-1:0] spb, logic [RANGE_W-1:0] start,
                            logic [RANGE_W-1:0] step_val);
    wait_idle();
    apb_write(REG_SPB, PDATA_W'(spb));
    apb_write(REG_START, PDATA_W'(start));
    apb_write(REG_STEP, PDATA_W'(step_val));
  endtask

  // Random mix: mostly pushes, a fair share of queries, some end-of-stream
  // beats and the odd clear.
  task automatic run_mix(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)      send_beat(FUNC_PUSH, rand_sample(), DISP_W'($urandom));
      else if (r < 76) send_beat(FUNC_EOS, rand_sample(), DISP_W'($urandom));
      else if (r < 98) send_beat(FUNC_QUERY, rand_sample(), rand_disp());
      else             send_beat(FUNC_CLEAR, rand_sample(), DISP_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings first: queries on an empty store, an
    // end of stream with nothing pending and a clear of an empty store.
    send_beat(FUNC_QUERY, rand_sample(), '0);
    send_beat(FUNC_QUERY, rand_sample(), '1);
    send_beat(FUNC_EOS, rand_sample(), DISP_W'($urandom));
    send_beat(FUNC_CLEAR, rand_sample(), DISP_W'($urandom));

    // Two-sample buckets: full-scale extremes, an all-positive bucket whose
    // minimum stays at zero, and a partial bucket closed by end of stream.
    wait_idle();
    apb_write(REG_SPB, PDATA_W'(2));
    send_beat(FUNC_PUSH, 16'sh7FFF, DISP_W'($urandom));
    send_beat(FUNC_PUSH, 16'sh8000, DISP_W'($urandom));
    send_beat(FUNC_PUSH, 16'sd5, DISP_W'($urandom));
    send_beat(FUNC_PUSH, 16'sd7, DISP_W'($urandom));
    send_beat(FUNC_PUSH, -16'sd1, DISP_W'($urandom));
    send_beat(FUNC_EOS, rand_sample(), DISP_W'($urandom));
    send_beat(FUNC_EOS, rand_sample(), DISP_W'($urandom));
    send_beat(FUNC_QUERY, rand_sample(), 12'd0);
    send_beat(FUNC_QUERY, rand_sample(), 12'd1);
    send_beat(FUNC_QUERY, rand_sample(), 12'd2);
    // Far past the stored buckets, so the range clamps to the last one.
    send_beat(FUNC_QUERY, rand_sample(), '1);
    send_beat(FUNC_CLEAR, rand_sample(), DISP_W'($urandom));
    send_beat(FUNC_QUERY, rand_sample(), 12'd0);
    send_beat(FUNC_PUSH, 16'sd3, DISP_W'($urandom));
    send_beat(FUNC_PUSH, -16'sd3, DISP_W'($urandom));
    send_beat(FUNC_QUERY, rand_sample(), 12'd0);

    // Random part. Single-sample buckets with a one-to-one window.
    set_window(13'd1, '0, 28'h0010000);
    run_mix(200);

    // Fractional start and step. The receiver holds off for a long stretch
    // while queries keep coming, so the output register fills and the input
    // stalls with a query waiting to deliver.
    set_window(13'd3, 28'h0008000, 28'h0018000);
    quiet_in = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) send_beat(FUNC_PUSH, rand_sample(), DISP_W'($urandom));
      else            send_beat(FUNC_QUERY, rand_sample(), rand_disp());
    end
    quiet_in = 1'b0;
    run_mix(260);

    // Longest legal bucket and the widest step: a query on display bucket 0 walks the whole store.
    set_window(13'd4096, '0, 28'hFFFFFFF);
    run_mix(150);

    // Largest start with a zero step: each query sees one clamped bucket.
    set_window(13'd7, 28'hFFFFFFF, '0);
    run_mix(200);

    // Assorted short buckets and windows of up to a few buckets per display bucket.
    for (int k = 0; k < 4; k++) begin
      set_window(SPB_W'($urandom_range(1, 16)), RANGE_W'($urandom_range(0, 24 << 16)),
                 RANGE_W'($urandom_range(0, 4 << 16)));
      run_mix(250);
    end

    // Fill the store with a zero bucket length, which acts as one, and keep
    // pushing so later buckets are dropped and the full flag comes up.
    set_window('0, '0, 28'h0010000);
    send_beat(FUNC_CLEAR, rand_sample(), DISP_W'($urandom));
    for (int i = 0; i < 4200; i++) begin
      if (i % 64 == 63) send_beat(FUNC_QUERY, rand_sample(), DISP_W'($urandom));
      else              send_beat(FUNC_PUSH, rand_sample(), DISP_W'($urandom));
    end
    send_beat(FUNC_EOS, rand_sample(), DISP_W'($urandom));
    send_beat(FUNC_QUERY, rand_sample(), '1);
    send_beat(FUNC_QUERY, rand_sample(), 12'd0);
    // One sweep over the whole full store, then a clear drops the full flag.
    wait_idle();
    apb_write(REG_STEP, PDATA_W'(28'hFFFFFFF));
    send_beat(FUNC_QUERY, rand_sample(), 12'd0);
    send_beat(FUNC_QUERY, rand_sample(), 12'd1);
    send_beat(FUNC_CLEAR, rand_sample(), DISP_W'($urandom));
    send_beat(FUNC_QUERY, rand_sample(), 12'd0);

    // Closing part, with no idling on either side: a bucket length past the
    // maximum acts as the maximum, so the first bucket closes on its 4096th
    // sample and end of stream closes the one-sample remainder.
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    set_window(13'h1FFF, '0, 28'h0010000);
    send_beat(FUNC_CLEAR, rand_sample(), DISP_W'($urandom));
    for (int i = 0; i < 4097; i++) begin
      if (i % 512 == 511) send_beat(FUNC_QUERY, rand_sample(), rand_disp());
      send_beat(FUNC_PUSH, rand_sample(), DISP_W'($urandom));
    end
    send_beat(FUNC_EOS, rand_sample(), DISP_W'($urandom));
    send_beat(FUNC_QUERY, rand_sample(), 12'd0);
    send_beat(FUNC_QUERY, rand_sample(), 12'd1);
    send_beat(FUNC_QUERY, rand_sample(), 12'd2);

    // Drain: every answer back, then the settle wait for stray results.
    wait_idle();

    $display("Covered %0d input beats and %0d answers; %0d buckets stored, %0d dropped full.",
             sb.beats, sb.answered, sb.closed, sb.lost);
    $display("Used %0d register writes: zero, one and over-maximum bucket lengths,",
             reg_writes);
    $display("zero and full-scale windows.");
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d answers never seen", sb.errors, sb.pending_answers.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: waveform_minmax_peak_store_unit.f
rtl/wmps_pkg.sv
rtl/wmps_regs.sv
rtl/wmps_peak_mem.sv
rtl/wmps_accum.sv
rtl/wmps_query.sv
rtl/waveform_minmax_peak_store_unit.sv
tb/tb_waveform_minmax_peak_store_unit.sv
